// ----- src/aes_ctr_pkg.sv -----
package aes_ctr_pkg;

  // Round key store: one 128-bit row per AES round key, up to 15 rows.
  localparam int RK_ROWS  = 15;
  localparam int RK_WIDTH = 128;
  localparam int RK_AW    = $clog2(RK_ROWS);

  // Configuration register indexes
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_IV_UP  = 3'd4;
  localparam logic [2:0] REG_IV_MID = 3'd5;
  localparam logic [2:0] REG_KSIZE  = 3'd6;
  localparam logic [2:0] REG_OFFSET = 3'd7;

  // Key size codes; the unused code behaves as a 256-bit key
  localparam logic [1:0] KSZ_128 = 2'd0;
  localparam logic [1:0] KSZ_192 = 2'd1;

  typedef struct packed {
    logic [7:0] data_in;
    logic       last_in;
  } req_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } res_t;

  // Keystream queue head, front to back
  typedef struct packed {
    logic         valid;
    logic [127:0] block;
  } ks_stat_t;

  // Back to front: release the head block, or drop everything and restart
  typedef struct packed {
    logic pop;
    logic flush;
  } ks_ctl_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // One AES round without the key add; byte 0 sits in the top bits.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_rnd);
    logic [7:0]   b [16];
    logic [7:0]   t [16];
    logic [7:0]   all_x;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      b[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = b[r+4*((c+r)&3)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all_x = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      if (final_rnd) begin
        o[127-32*c -: 32] = {t[4*c], t[4*c+1], t[4*c+2], t[4*c+3]};
      end else begin
        o[127-32*c -: 8]  = t[4*c]   ^ all_x ^ xtime(t[4*c]   ^ t[4*c+1]);
        o[119-32*c -: 8]  = t[4*c+1] ^ all_x ^ xtime(t[4*c+1] ^ t[4*c+2]);
        o[111-32*c -: 8]  = t[4*c+2] ^ all_x ^ xtime(t[4*c+2] ^ t[4*c+3]);
        o[103-32*c -: 8]  = t[4*c+3] ^ all_x ^ xtime(t[4*c+3] ^ t[4*c]);
      end
    end
    return o;
  endfunction

endpackage

// ----- src/aes_ctr_stream_cipher_unit.sv -----
// Channel   Handshake            Payload            Notes
// input     push / full          request (req_t)    one data byte plus last mark
// result    pop / empty          result (res_t)     oldest result first
// config    cfg_valid/cfg_ready  cfg_index,cfg_data ready always high
//
// One byte per cycle sustained unless full is raised. The AES core runs one
// round per cycle in a single round unit fed by the round key memory read port
// and turns out 16-byte keystream blocks.
// The first byte of a message waits for its first block.
// After reset or a key or key size write the key schedule is expanded one
// word per cycle while full stays high.
// A full result queue (two entries) stalls the input; a byte marked last
// drops any keystream run ahead and restarts the counter.
module aes_ctr_stream_cipher_unit
  import aes_ctr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        request,
  output logic        empty,
  input  logic        pop,
  output res_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] key_word0, key_word1, key_word2, key_word3, iv_upper;
  logic [31:0] iv_middle;
  logic [1:0]  key_size;
  logic [35:0] start_offset;
  logic        kick;
  logic        cfg_wr_last;

  logic                cfg_wr, key_wr, key_start, key_busy, keying;
  logic                rk_we;
  logic [RK_AW-1:0]    rk_waddr, rk_raddr;
  logic [RK_WIDTH-1:0] rk_wdata, rk_rdata;
  ks_stat_t            stat;
  ks_ctl_t             back_ctl, front_ctl;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    unique case (cfg_index) inside
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_KSIZE: key_wr = cfg_wr;
      default:                                           key_wr = 1'b0;
    endcase
  end

  // Expand the key after reset and after any write that changes it
  assign key_start = kick || key_wr;
  assign keying    = key_start || key_busy;

  // Flush queued keystream on config writes, key expansion and message end;
  // cfg_wr_last also flushes so the counter reloads from updated registers
  assign front_ctl.pop   = back_ctl.pop;
  assign front_ctl.flush = back_ctl.flush || cfg_wr || cfg_wr_last || keying;

  always_ff @(posedge clk) begin
    if (rst) begin
      kick         <= 1'b1;
      cfg_wr_last  <= 1'b0;
      key_word0    <= '0;
      key_word1    <= '0;
      key_word2    <= '0;
      key_word3    <= '0;
      iv_upper     <= '0;
      iv_middle    <= '0;
      key_size     <= '0;
      start_offset <= '0;
    end else begin
      kick        <= 1'b0;
      cfg_wr_last <= cfg_wr;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_KEY0:   key_word0    <= cfg_data;
          REG_KEY1:   key_word1    <= cfg_data;
          REG_KEY2:   key_word2    <= cfg_data;
          REG_KEY3:   key_word3    <= cfg_data;
          REG_IV_UP:  iv_upper     <= cfg_data;
          REG_IV_MID: iv_middle    <= cfg_data[31:0];
          REG_KSIZE:  key_size     <= cfg_data[1:0];
          REG_OFFSET: start_offset <= cfg_data[35:0];
          default:    ;
        endcase
      end
    end
  end

  aes_ctr_keyexp u_keyexp (
    .clk      (clk),
    .rst      (rst),
    .start    (key_start),
    .key      ({key_word0, key_word1, key_word2, key_word3}),
    .key_size (key_size),
    .busy     (key_busy),
    .rk_we    (rk_we),
    .rk_waddr (rk_waddr),
    .rk_wdata (rk_wdata)
  );

  aes_ctr_ram #(
    .WIDTH (RK_WIDTH),
    .DEPTH (RK_ROWS)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  aes_ctr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .ctr_init ({iv_upper, iv_middle, start_offset[35:4]}),
    .key_size (key_size),
    .ctl      (front_ctl),
    .stat     (stat),
    .rk_raddr (rk_raddr),
    .rk_rdata (rk_rdata)
  );

  aes_ctr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .hold      (keying),
    .start_pos (start_offset[3:0]),
    .push      (push),
    .full      (full),
    .request   (request),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .stat      (stat),
    .ctl       (back_ctl)
  );

endmodule

// ----- src/aes_ctr_ram.sv -----
module aes_ctr_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/aes_ctr_keyexp.sv -----
module aes_ctr_keyexp
  import aes_ctr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [255:0]        key,
  input  logic [1:0]          key_size,
  output logic                busy,
  output logic                rk_we,
  output logic [RK_AW-1:0]    rk_waddr,
  output logic [RK_WIDTH-1:0] rk_wdata
);

  logic [5:0]  idx;
  logic [2:0]  modc;
  logic [7:0]  rc;
  logic [31:0] win [8];
  logic [95:0] row;

  logic [3:0]  nk;
  logic [2:0]  nk_m1;
  logic [5:0]  total_m1;
  logic [31:0] key_w, sub_in, sub_out, tmp, word;

  always_comb begin
    unique case (key_size)
      KSZ_128: begin nk = 4'd4; nk_m1 = 3'd3; total_m1 = 6'd43; end
      KSZ_192: begin nk = 4'd6; nk_m1 = 3'd5; total_m1 = 6'd51; end
      default: begin nk = 4'd8; nk_m1 = 3'd7; total_m1 = 6'd59; end
    endcase
    key_w   = key[255 - 32*idx[2:0] -: 32];
    sub_in  = (modc == 3'd0) ? {win[0][23:0], win[0][31:24]} : win[0];
    sub_out = sub_word(sub_in);
    if (modc == 3'd0) begin
      tmp = sub_out ^ {rc, 24'd0};
    end else if (nk == 4'd8 && modc == 3'd4) begin
      tmp = sub_out;
    end else begin
      tmp = win[0];
    end
    word = ({2'd0, idx} < {4'd0, nk}) ? key_w : (win[nk_m1] ^ tmp);
  end

  assign rk_we    = busy && (idx[1:0] == 2'd3);
  assign rk_waddr = idx[5:2];
  assign rk_wdata = {row, word};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && idx == total_m1) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx  <= '0;
      modc <= '0;
      rc   <= 8'h01;
    end else if (busy) begin
      idx  <= idx + 6'd1;
      modc <= (modc == nk_m1) ? 3'd0 : modc + 3'd1;
      if (modc == 3'd0 && {2'd0, idx} >= {4'd0, nk}) begin
        rc <= xtime(rc);
      end
      win[0] <= word;
      for (int i = 1; i < 8; i++) begin
        win[i] <= win[i-1];
      end
      row <= {row[63:0], word};
    end
  end

endmodule

// ----- src/aes_ctr_front.sv -----
module aes_ctr_front
  import aes_ctr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [127:0]        ctr_init,
  input  logic [1:0]          key_size,
  input  ks_ctl_t             ctl,
  output ks_stat_t            stat,
  output logic [RK_AW-1:0]    rk_raddr,
  input  logic [RK_WIDTH-1:0] rk_rdata
);

  logic         busy;
  logic [3:0]   rnd;
  logic [127:0] state;
  logic [127:0] ctr;
  logic [127:0] q [2];
  logic [1:0]   cnt;

  logic [3:0]   nr;
  logic         finish, start, pop_ok;
  logic [127:0] round_out;
  logic [1:0]   occupied;

  always_comb begin
    unique case (key_size)
      KSZ_128: nr = 4'd10;
      KSZ_192: nr = 4'd12;
      default: nr = 4'd14;
    endcase
    finish    = busy && (rnd == nr);
    round_out = aes_round(state, rnd == nr) ^ rk_rdata;
    occupied  = cnt + {1'b0, busy};
    start     = !ctl.flush && (!busy || finish) && (occupied < 2'd2);
    pop_ok    = ctl.pop && (cnt != 2'd0);
    rk_raddr  = start ? '0 : RK_AW'(rnd + 4'd1);
  end

  assign stat.valid = (cnt != 2'd0);
  assign stat.block = q[0];

  always_ff @(posedge clk) begin
    if (rst || ctl.flush) begin
      busy <= 1'b0;
      cnt  <= '0;
      ctr  <= ctr_init;
    end else begin
      // hold the queue head until the back releases it
      if (start) begin
        busy <= 1'b1;
        ctr  <= ctr + 128'd1;
      end else if (finish) begin
        busy <= 1'b0;
      end
      cnt <= cnt + {1'b0, finish} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      state <= ctr;
      rnd   <= '0;
    end else if (busy && rnd == 4'd0) begin
      state <= state ^ rk_rdata;
      rnd   <= 4'd1;
    end else if (busy) begin
      state <= round_out;
      rnd   <= rnd + 4'd1;
    end
    if (pop_ok) begin
      q[0] <= q[1];
    end
    if (finish) begin
      if (cnt - {1'b0, pop_ok} == 2'd0) begin
        q[0] <= round_out;
      end else begin
        q[1] <= round_out;
      end
    end
  end

endmodule

// ----- src/aes_ctr_back.sv -----
module aes_ctr_back
  import aes_ctr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       hold,
  input  logic [3:0] start_pos,
  input  logic       push,
  output logic       full,
  input  req_t       request,
  output logic       empty,
  input  logic       pop,
  output res_t       result,
  input  ks_stat_t   stat,
  output ks_ctl_t    ctl
);

  logic [3:0] pos;
  logic       in_msg;
  res_t       ob [2];
  logic [1:0] cnt;

  logic       accept, pop_ok;
  logic [3:0] pos_used;
  res_t       res_new;

  always_comb begin
    full     = (cnt == 2'd2) || !stat.valid || hold;
    accept   = push && !full;
    pop_ok   = pop && (cnt != 2'd0);
    pos_used = in_msg ? pos : start_pos;
    res_new.data_out = request.data_in ^ stat.block[127 - 8*pos_used -: 8];
    res_new.last_out = request.last_in;
    ctl.flush = accept && request.last_in;
    ctl.pop   = accept && !request.last_in && (pos_used == 4'd15);
  end

  assign empty  = (cnt == 2'd0);
  assign result = ob[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_msg <= 1'b0;
      pos    <= '0;
      cnt    <= '0;
    end else begin
      if (accept) begin
        in_msg <= !request.last_in;
        pos    <= pos_used + 4'd1;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ok) begin
      ob[0] <= ob[1];
    end
    if (accept) begin
      if (cnt - {1'b0, pop_ok} == 2'd0) begin
        ob[0] <= res_new;
      end else begin
        ob[1] <= res_new;
      end
    end
  end

endmodule

// ----- bench/tb_aes_ctr_stream_cipher_unit.sv -----
`timescale 1ns / 1ps

module tb_aes_ctr_stream_cipher_unit;
  import aes_ctr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  req_t        request = '0;
  logic        empty;
  logic        pop = 1'b0;
  res_t        result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_ctr_stream_cipher_unit uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .request(request),
    .empty(empty), .pop(pop), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor state: configuration copy plus the cipher's running state.
  logic [63:0]  key_w [4];
  logic [63:0]  iv_up;
  logic [31:0]  iv_mid;
  logic [1:0]   key_sz;
  logic [35:0]  msg_offset;
  logic [127:0] ctr_blk;
  logic [127:0] ks_blk;
  logic [3:0]   byte_pos;
  logic         mid_message;
  logic [31:0]  rk [60];
  int           rounds;

  req_t byte_queue [$];
  res_t cipher_out_queue [$];

  int   idle_pct_tx;
  int   idle_pct_rx;
  int   error_count;
  int   quiet_cycles;
  bit   in_taken = 1'b0;

  function automatic logic [7:0] sb(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub4(input logic [31:0] w);
    return {sb(w[31:24]), sb(w[23:16]), sb(w[15:8]), sb(w[7:0])};
  endfunction

  // Build the round key schedule for the latched key size.
  task automatic build_schedule();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    if (key_sz == KSZ_128) begin
      nk = 4; rounds = 10;
    end else if (key_sz == KSZ_192) begin
      nk = 6; rounds = 12;
    end else begin
      nk = 8; rounds = 14;
    end
    for (int i = 0; i < 4; i++) begin
      rk[2*i]   = key_w[i][63:32];
      rk[2*i+1] = key_w[i][31:0];
    end
    rc = 8'h01;
    for (int i = nk; i < 4 * (rounds + 1); i++) begin
      t = rk[i-1];
      if (i % nk == 0) begin
        t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub4(t);
      end
      rk[i] = rk[i-nk] ^ t;
    end
  endtask

  // Encrypt one counter block; byte 0 is in the top bits.
  function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ rk[i/4][31-8*(i%4) -: 8];
    for (int rnd = 1; rnd <= rounds; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r+4*c] = sb(s[r+4*((c+r)%4)]);
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        if (rnd != rounds) begin
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          s[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          s[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          s[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end else begin
          s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[4*rnd + i/4][31-8*(i%4) -: 8];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  // Advance the cipher by one byte and queue the expected output.
  task automatic cipher_byte(input req_t rq);
    res_t ex;
    logic fetch;
    if (!mid_message) begin
      build_schedule();
      ctr_blk = {iv_up, iv_mid, msg_offset[35:4]};
      byte_pos = msg_offset[3:0];
      mid_message = 1'b1;
      fetch = 1'b1;
    end else begin
      fetch = (byte_pos == 4'd0);
    end
    if (fetch) begin
      ks_blk = encrypt_block(ctr_blk);
      ctr_blk = ctr_blk + 128'd1;
    end
    ex.data_out = rq.data_in ^ ks_blk[127-8*byte_pos -: 8];
    ex.last_out = rq.last_in;
    cipher_out_queue.push_back(ex);
    byte_pos = byte_pos + 4'd1;
    if (rq.last_in) mid_message = 1'b0;
  endtask

  // Driver: present the next queued byte, hold it until accepted.
  always @(negedge clk) begin
    if (!rst) begin
      if (push && in_taken) begin
        void'(byte_queue.pop_front());
      end
      if ((!push || in_taken) && byte_queue.size() > 0 &&
          $urandom_range(99) >= idle_pct_tx) begin
        push <= 1'b1;
        request <= byte_queue[0];
      end else if (!push || in_taken) begin
        push <= 1'b0;
        request <= {8'($urandom), 1'($urandom)};
      end
      pop <= ($urandom_range(99) >= idle_pct_rx);
    end
  end

  // Predict on accepted requests, check accepted results; run the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      in_taken = push && !full;
      if (push && !full) cipher_byte(request);
      if (pop && !empty) begin
        if (cipher_out_queue.size() == 0) begin
          $display("%0t: unexpected result %h", $time, result);
          error_count++;
        end else begin
          if (result.data_out !== cipher_out_queue[0].data_out) begin
            $display("%0t: data_out expected %h actual %h", $time,
                     cipher_out_queue[0].data_out, result.data_out);
            error_count++;
          end
          if (result.last_out !== cipher_out_queue[0].last_out) begin
            $display("%0t: last_out expected %b actual %b", $time,
                     cipher_out_queue[0].last_out, result.last_out);
            error_count++;
          end
          void'(cipher_out_queue.pop_front());
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_aes_ctr_stream_cipher_unit: done, errors");
        $finish;
      end
    end
  end

  // Write one register while the block is idle; mirror it in the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx) inside
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_w[idx[1:0]] = val;
      REG_IV_UP:  iv_up = val;
      REG_IV_MID: iv_mid = val[31:0];
      REG_KSIZE:  key_sz = val[1:0];
      REG_OFFSET: msg_offset = val[35:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    wait (byte_queue.size() == 0 && cipher_out_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_setup(input logic [1:0] ksz, input logic [35:0] off,
                            input logic [63:0] ivu, input logic [31:0] ivm);
    write_reg(REG_KEY0, {$urandom, $urandom});
    write_reg(REG_KEY1, {$urandom, $urandom});
    write_reg(REG_KEY2, {$urandom, $urandom});
    write_reg(REG_KEY3, {$urandom, $urandom});
    write_reg(REG_IV_UP, ivu);
    write_reg(REG_IV_MID, {32'($urandom), ivm});
    write_reg(REG_KSIZE, {62'($urandom), ksz});
    write_reg(REG_OFFSET, {28'($urandom), off});
  endtask

  // Queue a message of random bytes ending in a last mark.
  task automatic queue_message(input int len);
    for (int i = 0; i < len; i++)
      byte_queue.push_back({8'($urandom), (i == len - 1) ? 1'b1 : 1'b0});
  endtask

  initial begin
    logic [35:0] off;
    for (int i = 0; i < 4; i++) key_w[i] = '0;
    iv_up = '0; iv_mid = '0; key_sz = KSZ_128; msg_offset = '0;
    ctr_blk = '0; ks_blk = '0; byte_pos = '0; mid_message = 1'b0; rounds = 0;
    idle_pct_tx = 0; idle_pct_rx = 0; error_count = 0; quiet_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: all-zero key and FIPS-style defaults, byte extremes.
    byte_queue.push_back({8'h00, 1'b0});
    byte_queue.push_back({8'hff, 1'b0});
    byte_queue.push_back({8'ha5, 1'b1});
    drain();
    // Counter wraps across all 128 bits, unaligned start inside a block.
    write_reg(REG_IV_UP, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_IV_MID, 64'hffff_ffff);
    write_reg(REG_OFFSET, 64'hf_ffff_fffd);
    write_reg(REG_KSIZE, 64'd1);
    queue_message(6);
    drain();
    // Unused key size code, plus an offset that starts at the last byte of a block.
    write_reg(REG_KSIZE, 64'd3);
    write_reg(REG_OFFSET, 64'd15);
    queue_message(4);
    byte_queue.push_back({8'h5a, 1'b0});
    byte_queue.push_back({8'h3c, 1'b1});
    drain();
    write_reg(REG_KSIZE, 64'd2);
    queue_message(3);
    drain();

    // Random phases over several settings, including the extremes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct_tx = 0;  idle_pct_rx = 0;  end
        1: begin idle_pct_tx = 72; idle_pct_rx = 0;  end
        2: begin idle_pct_tx = 0;  idle_pct_rx = 72; end
        default: begin idle_pct_tx = 28; idle_pct_rx = 28; end
      endcase
      off = (ph == 0) ? 36'd0 : (ph == 7) ? 36'hf_ffff_ffff : 36'($urandom_range(40));
      if (ph == 5) off = {4'($urandom), 32'($urandom)};
      load_setup(2'(ph % 3), off, (ph == 7) ? '1 : {$urandom, $urandom},
                 (ph == 7) ? '1 : 32'($urandom));
      for (int m = 0; m < 6; m++) queue_message($urandom_range(1, 15));
      if (ph == 3) begin
        // Hold back until the block is empty, then continue.
        wait (byte_queue.size() == 0 && cipher_out_queue.size() == 0);
        queue_message(17);
      end
      drain();
    end
    idle_pct_tx = 0;
    idle_pct_rx = 0;
    drain();
    if (error_count == 0) begin
      $display("tb_aes_ctr_stream_cipher_unit: done, clean");
    end else begin
      $display("tb_aes_ctr_stream_cipher_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/aes_ctr_pkg.sv
src/aes_ctr_ram.sv
src/aes_ctr_keyexp.sv
src/aes_ctr_front.sv
src/aes_ctr_back.sv
src/aes_ctr_stream_cipher_unit.sv
bench/tb_aes_ctr_stream_cipher_unit.sv
